[src/bli_pkg.sv]
// Shared types, constants and helpers of the boot line title ID extractor.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none
package bli_pkg;

	localparam int unsigned ID_LEN = 11;
	localparam int unsigned TAG_LEN = 5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [3:0] CAP_RESET = 4'd12;
	localparam logic [3:0] ID_LEN_4  = 4'd11;

	typedef logic [ID_LEN-1:0][7:0] id_chars_t;

	typedef struct packed {
		logic       found;
		logic [3:0] count;
		id_chars_t  chars;
	} decision_t;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'b0001,
		PH_CAPTURE = 4'b0010,
		PH_SKIP    = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h42;
			3'd1: c = 8'h4F;
			3'd2: c = 8'h4F;
			3'd3: c = 8'h54;
			3'd4: c = 8'h32;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_up(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic pattern_ok(input id_chars_t s);
		return is_up(s[0]) && is_up(s[1]) && is_up(s[2]) && is_up(s[3]) &&
			(s[4] == CH_UNDER) && is_dig(s[5]) && is_dig(s[6]) && is_dig(s[7]) &&
			(s[8] == CH_DOT) && is_dig(s[9]) && is_dig(s[10]);
	endfunction

endpackage
`default_nettype wire

[src/boot_line_title_id_extractor_core.sv]
// Top level of the boot line title ID extractor: capacity register, scanner, queue, sequencer.
// Depends on bli_pkg, bli_front, bli_queue and bli_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------------
//  input    | push / full         | text_byte, final_byte
//  result   | pop / empty         | found, char_valid, id_char, char_position, run_end
//  config   | cfg_valid/cfg_ready | cfg_data (id_capacity)
//
// One text byte is taken per cycle unless full; a decision enters a two-entry queue the same cycle.
// Results leave one per cycle while pop is high, from the queue head, up to 11 per decision.
// full rises while both queue entries hold pending decisions.
// Reset restores id_capacity to 12 and the scanner to line start; no clearing pass.
`default_nettype none
module boot_line_title_id_extractor_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] text_byte,
	input  wire logic       final_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic            found,
	output logic            char_valid,
	output logic [7:0]      id_char,
	output logic [3:0]      char_position,
	output logic            run_end,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	logic               cap_wr;
	logic [3:0]         cap_q;
	logic               acc, rec_push, head_done, q_full, q_empty;
	bli_pkg::decision_t rec, head;

	assign cfg_ready = 1'b1;
	assign cap_wr    = cfg_valid && cfg_ready;
	assign acc       = push && !full;
	assign full      = q_full;
	assign empty     = q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bli_pkg::CAP_RESET;
		end else if (cap_wr) begin
			cap_q <= cfg_data;
		end
	end

	bli_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.cap        (cap_q),
		.rec_push   (rec_push),
		.rec        (rec)
	);

	bli_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rec_push),
		.wr_data (rec),
		.rd      (head_done),
		.rd_data (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	bli_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (!q_empty),
		.pop           (pop),
		.head_done     (head_done),
		.found         (found),
		.char_valid    (char_valid),
		.id_char       (id_char),
		.char_position (char_position),
		.run_end       (run_end)
	);

endmodule
`default_nettype wire

[src/bli_front.sv]
// Front end: scans text bytes, captures the ID on the boot line and forms a decision.
// Depends on bli_pkg.
`default_nettype none
module bli_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [7:0]        text_byte,
	input  wire logic              final_byte,
	input  wire logic [3:0]        cap,
	output logic                   rec_push,
	output bli_pkg::decision_t     rec
);

	bli_pkg::phase_t  phase_q, phase_a;
	logic [2:0]       prog_q, prog_a;
	logic [3:0]       cnt_q, cnt_a;
	bli_pkg::id_chars_t store_q, store_a;
	logic             eol, sep, dec_a, miss_a, decide;
	logic [3:0]       n_lim;

	assign eol = (text_byte == bli_pkg::CH_LF) || (text_byte == bli_pkg::CH_CR);
	assign sep = (text_byte == bli_pkg::CH_BSL) || (text_byte == bli_pkg::CH_SLASH) ||
		(text_byte == bli_pkg::CH_COLON);

	always_comb begin
		phase_a = phase_q;
		prog_a  = prog_q;
		cnt_a   = cnt_q;
		store_a = store_q;
		dec_a   = 1'b0;
		unique case (phase_q)
			bli_pkg::PH_PREFIX: begin
				if (eol) begin
					prog_a = 3'd0;
				end else if (prog_q < 3'(bli_pkg::TAG_LEN) &&
						text_byte == bli_pkg::tag_char(prog_q)) begin
					prog_a = prog_q + 3'd1;
					if (prog_a == 3'(bli_pkg::TAG_LEN)) begin
						phase_a = bli_pkg::PH_CAPTURE;
						cnt_a   = 4'd0;
					end
				end else begin
					phase_a = bli_pkg::PH_SKIP;
				end
			end
			bli_pkg::PH_CAPTURE: begin
				if (eol) begin
					dec_a   = 1'b1;
					phase_a = bli_pkg::PH_DONE;
				end else if (sep) begin
					cnt_a = 4'd0;
				end else if (cnt_q < bli_pkg::ID_LEN_4) begin
					store_a[cnt_q] = text_byte;
					cnt_a = cnt_q + 4'd1;
				end
			end
			bli_pkg::PH_SKIP: begin
				if (eol) begin
					phase_a = bli_pkg::PH_PREFIX;
					prog_a  = 3'd0;
				end
			end
			bli_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign decide = dec_a || (final_byte && phase_a == bli_pkg::PH_CAPTURE);
	assign miss_a = final_byte && phase_a != bli_pkg::PH_CAPTURE && phase_a != bli_pkg::PH_DONE;

	always_comb begin
		if (cap == 4'd0) begin
			n_lim = 4'd0;
		end else if (cap - 4'd1 > bli_pkg::ID_LEN_4) begin
			n_lim = bli_pkg::ID_LEN_4;
		end else begin
			n_lim = cap - 4'd1;
		end
	end

	assign rec_push  = acc && (decide || miss_a);
	assign rec.found = decide && (cnt_a == bli_pkg::ID_LEN_4) && bli_pkg::pattern_ok(store_a);
	assign rec.count = n_lim;
	assign rec.chars = store_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bli_pkg::PH_PREFIX;
			prog_q  <= 3'd0;
			cnt_q   <= 4'd0;
		end else if (acc) begin
			if (final_byte) begin
				phase_q <= bli_pkg::PH_PREFIX;
				prog_q  <= 3'd0;
				cnt_q   <= 4'd0;
			end else begin
				phase_q <= phase_a;
				prog_q  <= prog_a;
				cnt_q   <= cnt_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			store_q <= store_a;
		end
	end

endmodule
`default_nettype wire

[src/bli_queue.sv]
// Two-entry decision queue between the scanner and the result sequencer.
// Depends on bli_pkg.
`default_nettype none
module bli_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire bli_pkg::decision_t wr_data,
	input  wire logic               rd,
	output bli_pkg::decision_t      rd_data,
	output logic                    q_full,
	output logic                    q_empty
);

	bli_pkg::decision_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

[src/bli_back.sv]
// Back end: expands the oldest decision into its result requests, one per pop.
// Depends on bli_pkg.
`default_nettype none
module bli_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bli_pkg::decision_t head,
	input  wire logic               head_valid,
	input  wire logic               pop,
	output logic                    head_done,
	output logic                    found,
	output logic                    char_valid,
	output logic [7:0]              id_char,
	output logic [3:0]              char_position,
	output logic                    run_end
);

	logic [3:0] k_q;
	logic       take;

	assign found         = head.found;
	assign char_valid    = head.found && (head.count != 4'd0);
	assign id_char       = char_valid ? head.chars[k_q] : 8'd0;
	assign char_position = char_valid ? k_q : 4'd0;
	assign run_end       = !char_valid || (k_q == head.count - 4'd1);
	assign take          = pop && head_valid;
	assign head_done     = take && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 4'd0;
		end else if (take) begin
			k_q <= run_end ? 4'd0 : k_q + 4'd1;
		end
	end

endmodule
`default_nettype wire

[tb/sv/boot_line_title_id_extractor_core_test.sv]
// Self-checking testbench for boot_line_title_id_extractor_core: directed texts, then random texts
// under several idle/stall mixes, checked against a scanner model kept in this file.
// Depends on bli_pkg and the boot_line_title_id_extractor_core RTL.
module boot_line_title_id_extractor_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       found;
		logic       char_valid;
		logic [7:0] id_char;
		logic [3:0] char_position;
		logic       run_end;
	} title_result_t;

	typedef struct {
		string text;
		int    cap;
		bit    typed;
		bit    want_found;
		int    want_count;
	} directed_row_t;

	localparam logic [39:0] BOOT_TAG = "BOOT2";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       found;
	logic       char_valid;
	logic [7:0] id_char;
	logic [3:0] char_position;
	logic       run_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = 4'd0;

	bli_pkg::phase_t scan_st;
	logic [2:0]      tag_matched;
	logic [3:0]      kept_count;
	logic [7:0]      kept_chars [bli_pkg::ID_LEN];
	logic [3:0]      capacity;

	title_result_t expected_title_results[$];
	logic [7:0]    text_buf[$];
	int            predicted_results = 0;
	int            scanned_bytes = 0;
	bit            last_found_predicted = 1'b0;
	int            mismatches = 0;
	int            send_idle = 0;
	int            recv_stall = 0;
	int            hold_left = 0;

	directed_row_t directed_rows[9] = '{
		'{"BOOT2:ABCD_123.45", -1, 1'b1, 1'b1, 11},
		'{"#~\n~", -1, 1'b1, 1'b0, 1},
		'{"BOOT2 x/AB_1\nZ", -1, 1'b1, 1'b0, 1},
		'{"BOOT2ZZZZ_999.99\rq", 0, 1'b1, 1'b1, 1},
		'{"BOOT2\\AAAA_000.00;1", 15, 1'b1, 1'b1, 11},
		'{"BOOT2c:\\XY/QRST_456.78\r\n", 1, 1'b1, 1'b1, 1},
		'{"BO\rBOOT2/WXYZ_012.34~", 2, 1'b0, 1'b0, 0},
		'{"xBOOT2/ABCD_123.45\nBOOT2/ABCD_123.45", 5, 1'b0, 1'b0, 0},
		'{"BOOT2/abcd_123.45\n", 12, 1'b1, 1'b0, 1}
	};

	boot_line_title_id_extractor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.empty(empty),
		.pop(pop),
		.found(found),
		.char_valid(char_valid),
		.id_char(id_char),
		.char_position(char_position),
		.run_end(run_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("boot_line_title_id_extractor_core regression: fail");
		$finish;
	end

	function automatic void rearm_scanner();
		scan_st = bli_pkg::PH_PREFIX;
		tag_matched = 3'd0;
		kept_count = 4'd0;
	endfunction

	function automatic void add_expected(input title_result_t r);
		expected_title_results.push_back(r);
		predicted_results++;
		last_found_predicted = r.found;
	endfunction

	function automatic bit title_id_well_formed();
		bit ok;
		ok = (kept_count == bli_pkg::ID_LEN_4);
		for (int i = 0; i < 4; i++)
			ok &= (kept_chars[i] >= "A") && (kept_chars[i] <= "Z");
		ok &= (kept_chars[4] == bli_pkg::CH_UNDER) && (kept_chars[8] == bli_pkg::CH_DOT);
		for (int i = 5; i < 11; i++)
			if (i != 8)
				ok &= (kept_chars[i] >= "0") && (kept_chars[i] <= "9");
		return ok;
	endfunction

	function automatic void emit_decision();
		int n;
		if (!title_id_well_formed()) begin
			add_expected('{1'b0, 1'b0, 8'h00, 4'd0, 1'b1});
			return;
		end
		n = (capacity == 4'd0) ? 0 : int'(capacity) - 1;
		if (n > bli_pkg::ID_LEN)
			n = bli_pkg::ID_LEN;
		if (n == 0) begin
			add_expected('{1'b1, 1'b0, 8'h00, 4'd0, 1'b1});
			return;
		end
		for (int k = 0; k < n; k++)
			add_expected('{1'b1, 1'b1, kept_chars[k], 4'(k), k == n - 1});
	endfunction

	function automatic void advance_scanner(input logic [7:0] b, input logic fin);
		bit eol;
		eol = (b == bli_pkg::CH_LF) || (b == bli_pkg::CH_CR);
		case (scan_st)
			bli_pkg::PH_PREFIX: begin
				if (eol) begin
					tag_matched = 3'd0;
				end else if (tag_matched < 3'd5 && b == BOOT_TAG[39 - 8 * tag_matched -: 8]) begin
					tag_matched++;
					if (tag_matched == 3'd5) begin
						scan_st = bli_pkg::PH_CAPTURE;
						kept_count = 4'd0;
					end
				end else begin
					scan_st = bli_pkg::PH_SKIP;
				end
			end
			bli_pkg::PH_CAPTURE: begin
				if (eol) begin
					emit_decision();
					scan_st = bli_pkg::PH_DONE;
				end else if (b == bli_pkg::CH_BSL || b == bli_pkg::CH_SLASH ||
						b == bli_pkg::CH_COLON) begin
					kept_count = 4'd0;
				end else if (kept_count < bli_pkg::ID_LEN_4) begin
					kept_chars[kept_count] = b;
					kept_count++;
				end
			end
			bli_pkg::PH_SKIP: begin
				if (eol) begin
					scan_st = bli_pkg::PH_PREFIX;
					tag_matched = 3'd0;
				end
			end
			default: ;
		endcase
		if (fin) begin
			if (scan_st == bli_pkg::PH_CAPTURE)
				emit_decision();
			else if (scan_st != bli_pkg::PH_DONE)
				add_expected('{1'b0, 1'b0, 8'h00, 4'd0, 1'b1});
			rearm_scanner();
		end
	endfunction

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	function automatic void put_title_id(input int flavor);
		logic [7:0] id [bli_pkg::ID_LEN];
		string      edges;
		int         keep;
		int         pos;
		edges = "@[/:`{_.9A";
		for (int i = 0; i < 4; i++)
			id[i] = 8'h41 + 8'($urandom_range(0, 25));
		id[4] = bli_pkg::CH_UNDER;
		for (int i = 5; i < 11; i++)
			id[i] = 8'h30 + 8'($urandom_range(0, 9));
		id[8] = bli_pkg::CH_DOT;
		if (flavor == 1) begin
			pos = $urandom_range(0, 10);
			if ($urandom_range(0, 1) == 0)
				id[pos] = 8'($urandom_range(0, 255));
			else
				id[pos] = edges[$urandom_range(0, edges.len() - 1)];
		end
		keep = (flavor == 2) ? $urandom_range(0, 10) : 11;
		for (int i = 0; i < keep; i++)
			text_buf.push_back(id[i]);
	endfunction

	function automatic void put_eol();
		case ($urandom_range(0, 2))
			0: text_buf.push_back(bli_pkg::CH_CR);
			1: text_buf.push_back(bli_pkg::CH_LF);
			default: begin
				text_buf.push_back(bli_pkg::CH_CR);
				text_buf.push_back(bli_pkg::CH_LF);
			end
		endcase
	endfunction

	function automatic void build_text();
		int kind;
		int flavor;
		text_buf.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12))
				text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: begin
					put_str("BOO");
					text_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
				end
				1: put_str(" BOOT2/ABCD_123.45");
				2: repeat ($urandom_range(1, 6))
					text_buf.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
			put_eol();
		end
		if (kind == 1) begin
			put_str("BOOT");
			text_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_str("BOOT2");
		end
		case ($urandom_range(0, 5))
			0: ;
			1: put_str(" cdrom0:\\");
			2: put_str(":");
			3: put_str("/x/");
			4: put_str("mc0:/APPS/");
			default: begin
				repeat ($urandom_range(1, 3))
					text_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
				put_str("\\");
			end
		endcase
		flavor = $urandom_range(0, 9);
		put_title_id(flavor < 7 ? 0 : (flavor < 9 ? 1 : 2));
		case ($urandom_range(0, 3))
			0: put_str(";1");
			1: repeat ($urandom_range(1, 3))
				text_buf.push_back(8'($urandom_range(0, 255)));
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0) begin
			put_eol();
			case ($urandom_range(0, 2))
				0: begin
					put_str("BOOT2:");
					put_title_id(0);
				end
				1: repeat ($urandom_range(1, 4))
					text_buf.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (scan_st != bli_pkg::PH_DONE)
			scanned_bytes++;
		advance_scanner(b, fin);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic hold_input_until_drained();
		@(negedge clk);
		push <= 1'b0;
		while (expected_title_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [3:0] v);
		hold_input_until_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		capacity = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		title_result_t got;
		title_result_t want;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall);
			end
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got = '{found, char_valid, id_char, char_position, run_end};
				if (expected_title_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: found=%b valid=%b char=%h pos=%0d end=%b",
							got.found, got.char_valid, got.id_char, got.char_position, got.run_end);
				end else begin
					want = expected_title_results.pop_front();
					if (got.found !== want.found || got.char_valid !== want.char_valid ||
						got.id_char !== want.id_char ||
						got.char_position !== want.char_position ||
						got.run_end !== want.run_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: exp found=%b valid=%b char=%h pos=%0d end=%b",
								want.found, want.char_valid, want.id_char, want.char_position,
								want.run_end);
							$display("                 got found=%b valid=%b char=%h pos=%0d end=%b",
								got.found, got.char_valid, got.id_char, got.char_position,
								got.run_end);
						end
					end
				end
			end
		end
	end

	initial begin
		int         base_results;
		int         base_bytes;
		bit         mid_written;
		logic [7:0] c;
		int         send_mix[4];
		int         stall_mix[4];
		logic [3:0] mode_caps[4];

		send_mix = '{0, 55, 0, 32};
		stall_mix = '{0, 0, 55, 32};
		mode_caps = '{4'd11, 4'd1, 4'd13, 4'd12};
		capacity = bli_pkg::CAP_RESET;
		for (int i = 0; i < bli_pkg::ID_LEN; i++)
			kept_chars[i] = 8'h00;
		rearm_scanner();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].cap >= 0)
				write_capacity(4'(directed_rows[r].cap));
			base_results = predicted_results;
			text_buf.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++) begin
				c = directed_rows[r].text[i];
				if (c == "#")
					c = 8'h00;
				else if (c == "~")
					c = 8'hFF;
				text_buf.push_back(c);
			end
			send_text();
			if (directed_rows[r].typed &&
				(predicted_results - base_results != directed_rows[r].want_count ||
				last_found_predicted != directed_rows[r].want_found)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed text %0d: exp found=%b count=%0d, got found=%b count=%0d",
						r, directed_rows[r].want_found, directed_rows[r].want_count,
						last_found_predicted, predicted_results - base_results);
			end
		end

		for (int m = 0; m < 4; m++) begin
			write_capacity(mode_caps[m]);
			send_idle = send_mix[m];
			recv_stall = stall_mix[m];
			base_bytes = scanned_bytes;
			mid_written = 1'b0;
			while (scanned_bytes - base_bytes < 25) begin
				if (!mid_written && scanned_bytes - base_bytes >= 12) begin
					write_capacity(4'($urandom_range(0, 15)));
					mid_written = 1'b1;
				end
				build_text();
				send_text();
			end
		end

		write_capacity(bli_pkg::CAP_RESET);
		send_idle = 0;
		recv_stall = 0;
		hold_left = 300;
		repeat (4) begin
			text_buf.delete();
			put_str("BOOT2/");
			put_title_id(0);
			send_text();
		end
		hold_input_until_drained();
		repeat (2) begin
			build_text();
			send_text();
		end

		hold_input_until_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_title_results.size() == 0)
			$display("boot_line_title_id_extractor_core regression: pass");
		else
			$display("boot_line_title_id_extractor_core regression: fail");
		$finish;
	end

endmodule
